// ----- design/rtsm_pkg.sv -----
package rtsm_pkg;

	localparam int TASK_SLOTS  = 8;
	localparam int MUTEX_SLOTS = 4;
	localparam int TASK_W      = $clog2(TASK_SLOTS);
	localparam int MUTEX_W     = $clog2(MUTEX_SLOTS);
	localparam int RING_W      = $clog2(TASK_SLOTS + 1);
	localparam int FILL_W      = $clog2(TASK_SLOTS + 1);
	localparam int TIME_W      = 32;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_DELAY   = 2'd1,
		CMD_ACQUIRE = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCHED,
		S_DONE
	} state_t;

	localparam logic [2:0] REG_ACTIVE_TASKS = 3'd0;

	typedef struct packed {
		logic              tick;
		logic [TIME_W-1:0] now;
		logic [RING_W-1:0] ring_n;
		logic              block;
		logic              load_wake;
		logic [TIME_W-1:0] wake;
		logic [TASK_W-1:0] blk_idx;
		logic              wake_up;
		logic [TASK_W-1:0] rdy_idx;
	} task_ctl_t;

endpackage

// ----- design/rtos_task_scheduler_with_mutex_top.sv -----
// Round-robin task scheduler with four mutexes. Each transaction on the command
// channel yields one result transaction. A command is decoded and applied in order:
// the wait-queue memory read at acceptance, then the update. A tick, a blocking
// delay or a blocking acquire then walks the ring one task slot per cycle, visiting
// each ring slot at most once. The ring size is active_tasks, with zero taken as one
// and values above eight taken as eight. The ring size is set through the APB register
// at address 0.
module rtos_task_scheduler_with_mutex_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] delay_ticks,
	input  logic [1:0]  mutex_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  running_task,
	output logic [1:0]  status,
	output logic [7:0]  ready_mask
);

	localparam int TS = rtsm_pkg::TASK_SLOTS;
	localparam int MS = rtsm_pkg::MUTEX_SLOTS;
	localparam int TW = rtsm_pkg::TASK_W;
	localparam int MW = rtsm_pkg::MUTEX_W;
	localparam int RW = rtsm_pkg::RING_W;
	localparam int FW = rtsm_pkg::FILL_W;
	localparam int DW = rtsm_pkg::TIME_W;

	rtsm_pkg::state_t  state_q, state_d;
	logic [3:0]        active_q;
	logic [RW-1:0]     ring_n;
	logic [DW-1:0]     tick_q;
	logic [TW-1:0]     current_q;
	rtsm_pkg::cmd_t    cmd_q;
	logic [DW-1:0]     dly_q;
	logic [MW-1:0]     mid_q;
	logic [TW-1:0]     rd_q;
	logic [MS-1:0]     locked_q;
	logic [TW-1:0]     owner_q [MS];
	logic [TW-1:0]     head_q  [MS];
	logic [FW-1:0]     fill_q  [MS];
	logic [TW-1:0]     wq_mem  [MS*TS];
	logic [TW-1:0]     cand_q;
	logic [RW-1:0]     step_q;
	logic [1:0]        status_q;
	logic              sched_q;
	logic              out_valid_q;
	logic [TW-1:0]     out_task_q;
	logic [1:0]        out_status_q;
	logic [7:0]        out_mask_q;

	rtsm_pkg::task_ctl_t ctl;
	logic [TS-1:0]       ready_vec;
	logic [TS:0]         ready_chain;
	logic                in_acc, cfg_wr;
	logic                own_ok, do_sched, q_write;
	logic [TW-1:0]       nxt;
	logic                walk_end, walk_take;
	logic [TW-1:0]       tail;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == rtsm_pkg::REG_ACTIVE_TASKS);
	assign prdata = (paddr == rtsm_pkg::REG_ACTIVE_TASKS) ? {28'd0, active_q} : 32'd0;

	assign ring_n = (active_q == 4'd0) ? RW'(1) :
		(32'(active_q) > 32'(TS)) ? RW'(TS) : RW'(active_q);

	assign in_stall = (state_q != rtsm_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd1;
		end else if (cfg_wr) begin
			active_q <= pwdata[3:0];
		end
	end

	// task cells
	assign ready_chain[0] = 1'b0;
	for (genvar g = 0; g < TS; g++) begin : g_cell
		rtsm_task_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (TW'(g)),
			.ctl       (ctl),
			.ready_in  (ready_chain[g]),
			.ready_out (ready_chain[g+1]),
			.ready     (ready_vec[g])
		);
	end

	assign own_ok = locked_q[mid_q] && owner_q[mid_q] == current_q;
	assign tail   = head_q[mid_q] + TW'(fill_q[mid_q]);
	assign q_write = (state_q == rtsm_pkg::S_EXEC) && cmd_q == rtsm_pkg::CMD_ACQUIRE &&
		locked_q[mid_q] && fill_q[mid_q] < FW'(TS);

	always_comb begin
		ctl           = '0;
		ctl.ring_n    = ring_n;
		ctl.now       = tick_q + DW'(1);
		ctl.wake      = tick_q + dly_q;
		ctl.blk_idx   = current_q;
		ctl.rdy_idx   = rd_q;
		do_sched      = 1'b0;
		if (state_q == rtsm_pkg::S_EXEC) begin
			case (cmd_q)
				rtsm_pkg::CMD_TICK: begin
					ctl.tick = 1'b1;
					do_sched = 1'b1;
				end
				rtsm_pkg::CMD_DELAY: begin
					ctl.block     = dly_q != '0;
					ctl.load_wake = 1'b1;
					do_sched      = dly_q != '0;
				end
				rtsm_pkg::CMD_ACQUIRE: begin
					ctl.block = locked_q[mid_q];
					do_sched  = locked_q[mid_q];
				end
				default: begin
					ctl.wake_up = own_ok && fill_q[mid_q] != '0;
				end
			endcase
		end
	end

	assign nxt       = ({1'b0, cand_q} + RW'(1) >= ring_n) ? '0 : cand_q + TW'(1);
	assign walk_take = nxt != current_q && ready_vec[nxt];
	assign walk_end  = nxt == current_q || ready_vec[nxt] || step_q + RW'(1) >= ring_n;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtsm_pkg::S_IDLE:  if (in_acc) state_d = rtsm_pkg::S_EXEC;
			rtsm_pkg::S_EXEC:  state_d = do_sched ? rtsm_pkg::S_SCHED : rtsm_pkg::S_DONE;
			rtsm_pkg::S_SCHED: if (walk_end) state_d = rtsm_pkg::S_DONE;
			rtsm_pkg::S_DONE:  if (!out_valid_q || !out_stall) state_d = rtsm_pkg::S_IDLE;
			default:           state_d = rtsm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtsm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= wq_mem[{mutex_id, head_q[mutex_id]}];
		end
		if (q_write) begin
			wq_mem[{mid_q, tail}] <= current_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= rtsm_pkg::CMD_TICK;
			dly_q <= '0;
			mid_q <= '0;
		end else if (in_acc) begin
			cmd_q <= rtsm_pkg::cmd_t'(cmd);
			dly_q <= delay_ticks;
			mid_q <= mutex_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			current_q <= '0;
			locked_q  <= '0;
			status_q  <= rtsm_pkg::ST_DONE;
			sched_q   <= 1'b0;
			cand_q    <= '0;
			step_q    <= '0;
			for (int i = 0; i < MS; i++) begin
				owner_q[i] <= '0;
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
		end else begin
			if (state_q == rtsm_pkg::S_EXEC) begin
				cand_q   <= current_q;
				step_q   <= '0;
				sched_q  <= do_sched;
				status_q <= rtsm_pkg::ST_DONE;
				case (cmd_q)
					rtsm_pkg::CMD_TICK: begin
						tick_q <= tick_q + DW'(1);
					end
					rtsm_pkg::CMD_DELAY: begin
						if (dly_q != '0) status_q <= rtsm_pkg::ST_BLOCKED;
					end
					rtsm_pkg::CMD_ACQUIRE: begin
						if (!locked_q[mid_q]) begin
							locked_q[mid_q] <= 1'b1;
							owner_q[mid_q]  <= current_q;
						end else begin
							status_q <= rtsm_pkg::ST_BLOCKED;
							if (fill_q[mid_q] < FW'(TS)) begin
								fill_q[mid_q] <= fill_q[mid_q] + FW'(1);
							end
						end
					end
					default: begin
						if (!own_ok) begin
							status_q <= rtsm_pkg::ST_REFUSED;
						end else if (fill_q[mid_q] != '0) begin
							head_q[mid_q]  <= head_q[mid_q] + TW'(1);
							fill_q[mid_q]  <= fill_q[mid_q] - FW'(1);
							owner_q[mid_q] <= rd_q;
						end else begin
							locked_q[mid_q] <= 1'b0;
							owner_q[mid_q]  <= '0;
						end
					end
				endcase
			end
			if (state_q == rtsm_pkg::S_SCHED) begin
				cand_q <= nxt;
				step_q <= step_q + RW'(1);
				if (walk_take) begin
					current_q <= nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rtsm_pkg::S_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtsm_pkg::S_DONE && (!out_valid_q || !out_stall)) begin
			out_task_q   <= current_q;
			out_status_q <= status_q;
			out_mask_q   <= 8'(ready_vec);
		end
	end

	assign out_valid    = out_valid_q;
	assign running_task = out_task_q;
	assign status       = out_status_q;
	assign ready_mask   = out_mask_q;

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtsm_pkg::S_SCHED |-> step_q < ring_n)
		else $error("schedule walk ran past the ring");

	a_walk_only_sched: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtsm_pkg::S_SCHED |-> sched_q)
		else $error("walk entered without a schedule request");

	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q[mid_q] |-> fill_q[mid_q] == '0)
		else $error("unlocked mutex has waiters");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[mid_q] <= FW'(TS))
		else $error("wait queue over capacity");

	a_no_ready_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtsm_pkg::S_SCHED && !ready_chain[TS] |=> $stable(current_q))
		else $error("switched task with nothing ready");

endmodule

// ----- design/rtsm_task_cell.sv -----
module rtsm_task_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rtsm_pkg::TASK_W-1:0] idx,
	input  rtsm_pkg::task_ctl_t       ctl,
	input  logic                      ready_in,
	output logic                      ready_out,
	output logic                      ready
);

	logic                        ready_q;
	logic [rtsm_pkg::TIME_W-1:0] wake_q;
	logic                        in_ring;

	assign in_ring = {1'b0, idx} < ctl.ring_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b1;
			wake_q  <= '0;
		end else begin
			if (ctl.tick && in_ring && !ready_q && wake_q != '0 && ctl.now >= wake_q) begin
				ready_q <= 1'b1;
				wake_q  <= '0;
			end
			if (ctl.block && idx == ctl.blk_idx) begin
				ready_q <= 1'b0;
				if (ctl.load_wake) begin
					wake_q <= ctl.wake;
				end
			end
			if (ctl.wake_up && idx == ctl.rdy_idx) begin
				ready_q <= 1'b1;
			end
		end
	end

	// ready chain: any ready task at or below this cell
	assign ready_out = ready_in | ready_q;
	assign ready     = ready_q;

endmodule
